// File: design/assert_macros.svh
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/sle_pkg.sv
// Shared types, codes and echo tables of the serial line editor.
package sle_pkg;

	localparam int POS_W = 5;
	localparam int BYTE_W = 8;
	localparam int CHAR_W = 7;
	localparam int KIND_W = 2;

	localparam logic [POS_W-1:0] MAX_LEN_RESET = 5'd20;

	localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CHAR = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;

	localparam logic [BYTE_W-1:0] CODE_BS = 8'd8;
	localparam logic [BYTE_W-1:0] CODE_TAB = 8'd9;
	localparam logic [BYTE_W-1:0] CODE_CR = 8'd13;
	localparam logic [BYTE_W-1:0] CODE_ESC = 8'd27;
	localparam logic [BYTE_W-1:0] CODE_SPACE = 8'd32;
	localparam logic [BYTE_W-1:0] CODE_TOP = 8'd127;

	typedef logic [2:0] cls_t;
	localparam cls_t CLS_NONE = 3'd0;
	localparam cls_t CLS_PRINT = 3'd1;
	localparam cls_t CLS_CR = 3'd2;
	localparam cls_t CLS_BS = 3'd3;
	localparam cls_t CLS_TAB = 3'd4;
	localparam cls_t CLS_ESC = 3'd5;

	typedef struct packed {
		logic capture;
		logic load_echo;
		logic load_char;
		logic load_done;
		logic rd_en;
		logic cnt_inc;
	} cmd_t;

	typedef struct packed {
		cls_t cls_in;
		logic echo_last;
		logic rd_end;
		logic slot_free;
	} sts_t;

	function automatic cls_t classify(input logic [BYTE_W-1:0] b);
		cls_t c;
		c = CLS_NONE;
		if (b >= CODE_SPACE && b <= CODE_TOP) begin
			c = CLS_PRINT;
		end else if (b == CODE_CR) begin
			c = CLS_CR;
		end else if (b == CODE_BS) begin
			c = CLS_BS;
		end else if (b == CODE_TAB) begin
			c = CLS_TAB;
		end else if (b == CODE_ESC) begin
			c = CLS_ESC;
		end
		return c;
	endfunction

	function automatic logic [POS_W-1:0] echo_len(input cls_t c);
		logic [POS_W-1:0] n;
		case (c)
			CLS_PRINT: n = 5'd1;
			CLS_BS: n = 5'd3;
			default: n = 5'd5;
		endcase
		return n;
	endfunction

	function automatic logic [BYTE_W-1:0] echo_byte(input cls_t c, input logic [2:0] step,
			input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] r;
		r = b;
		case (c)
			CLS_BS: r = (step == 3'd1) ? CODE_SPACE : CODE_BS;
			CLS_TAB: begin
				case (step)
					3'd0: r = 8'd60;
					3'd1: r = 8'd84;
					3'd2: r = 8'd65;
					3'd3: r = 8'd66;
					default: r = 8'd62;
				endcase
			end
			CLS_ESC: begin
				case (step)
					3'd0: r = 8'd60;
					3'd1: r = 8'd69;
					3'd2: r = 8'd83;
					3'd3: r = 8'd67;
					default: r = 8'd62;
				endcase
			end
			default: r = b;
		endcase
		return r;
	endfunction

endpackage

// File: design/serial_line_editor.sv
// Sequencing: an echo result passes from the ECHO state into the output register; a carriage
// return reads each stored character through the RDADDR and RDDATA states, then loads the
// completion result in the DONE state. Each result waits for a free output slot. Requests are
// taken only in IDLE, so no new byte is taken until all results of the last one are loaded.
// Reset: arst_n clears the write position, the state machine and the output valid and
// loads the maximum line length with 20; the line store itself is not cleared.
`include "assert_macros.svh"

module serial_line_editor #(
	parameter int LINE_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [1:0] result_kind, [9:2] result_data, [15:10] zero
	output logic        m_tlast,   // last_of_run
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data   // max_line_length
);
	import sle_pkg::*;

	cmd_t              cmd;
	sts_t              sts;
	logic [KIND_W-1:0] out_kind;
	logic [BYTE_W-1:0] out_data;

	sle_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(s_tvalid),
		.req_ready(s_tready),
		.sts(sts),
		.cmd(cmd)
	);

	sle_dpath #(
		.LINE_DEPTH(LINE_DEPTH)
	) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.rx_byte(s_tdata),
		.cfg_valid(cfg_valid),
		.cfg_data(cfg_data),
		.cmd(cmd),
		.sts(sts),
		.out_ready(m_tready),
		.out_valid(m_tvalid),
		.out_kind(out_kind),
		.out_data(out_data),
		.out_last(m_tlast)
	);

	assign cfg_ready = 1'b1;
	assign m_tdata = {6'b000000, out_data, out_kind};

	`ASSERT_ALWAYS(a_one_load, $onehot0({cmd.load_echo, cmd.load_char, cmd.load_done}),
		"more than one result loaded at once")
	`ASSERT_IMPLIES(a_load_free, cmd.load_echo || cmd.load_char || cmd.load_done,
		sts.slot_free, "result loaded over a pending result")
	`ASSERT_IMPLIES(a_read_range, cmd.rd_en, !sts.rd_end, "line read beyond its length")
	`ASSERT_NEXT(a_done_last, cmd.load_done, m_tvalid && m_tlast,
		"line complete result not marked last")

endmodule

// File: design/sle_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/sle_ctrl.sv
// Controller state machine that sequences echo, line readout and completion results.
module sle_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  sle_pkg::sts_t sts,
	output sle_pkg::cmd_t cmd
);
	import sle_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ECHO = 3'd1;
	localparam logic [2:0] ST_RDADDR = 3'd2;
	localparam logic [2:0] ST_RDDATA = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					unique case (sts.cls_in) inside
						CLS_PRINT, CLS_BS, CLS_TAB, CLS_ESC: state_d = ST_ECHO;
						CLS_CR: state_d = ST_RDADDR;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_ECHO: begin
				if (sts.slot_free) begin
					cmd.load_echo = 1'b1;
					if (sts.echo_last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.cnt_inc = 1'b1;
					end
				end
			end
			ST_RDADDR: begin
				if (sts.rd_end) begin
					state_d = ST_DONE;
				end else begin
					cmd.rd_en = 1'b1;
					state_d = ST_RDDATA;
				end
			end
			ST_RDDATA: begin
				if (sts.slot_free) begin
					cmd.load_char = 1'b1;
					cmd.cnt_inc = 1'b1;
					state_d = ST_RDADDR;
				end
			end
			ST_DONE: begin
				if (sts.slot_free) begin
					cmd.load_done = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// File: design/sle_dpath.sv
// Datapath with line store, write position, step counter and output register.
module sle_dpath #(
	parameter int LINE_DEPTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [sle_pkg::BYTE_W-1:0]   rx_byte,
	input  logic                         cfg_valid,
	input  logic [sle_pkg::POS_W-1:0]    cfg_data,
	input  sle_pkg::cmd_t                cmd,
	output sle_pkg::sts_t                sts,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic [sle_pkg::KIND_W-1:0]   out_kind,
	output logic [sle_pkg::BYTE_W-1:0]   out_data,
	output logic                         out_last
);
	import sle_pkg::*;

	localparam int AW = $clog2(LINE_DEPTH);

	logic [POS_W-1:0]  max_q;
	logic [POS_W-1:0]  wp_q;
	logic [POS_W-1:0]  cnt_q;
	cls_t              seq_q;
	logic [BYTE_W-1:0] byte_q;
	logic              oval_q;
	logic [KIND_W-1:0] okind_q;
	logic [BYTE_W-1:0] odata_q;
	logic              olast_q;

	cls_t              cls_in;
	logic              store_ok;
	logic [AW+POS_W-1:0] wp_ext;
	logic [AW+POS_W-1:0] cnt_ext;
	logic [AW-1:0]     waddr;
	logic [AW-1:0]     raddr;
	logic [CHAR_W-1:0] rdata;
	logic              echo_last;

	assign cls_in = classify(rx_byte);
	assign store_ok = (wp_q < max_q) && (32'(wp_q) < LINE_DEPTH);
	assign wp_ext = {{AW{1'b0}}, wp_q};
	assign cnt_ext = {{AW{1'b0}}, cnt_q};
	assign waddr = wp_ext[AW-1:0];
	assign raddr = cnt_ext[AW-1:0];
	assign echo_last = (cnt_q == echo_len(seq_q) - 5'd1);

	sle_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(LINE_DEPTH)
	) u_store (
		.clk(clk),
		.we(cmd.capture && cls_in == CLS_PRINT && store_ok),
		.waddr(waddr),
		.wdata(rx_byte[CHAR_W-1:0]),
		.re(cmd.rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_LEN_RESET;
			wp_q <= '0;
			cnt_q <= '0;
			seq_q <= CLS_NONE;
			oval_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				max_q <= cfg_data;
			end
			if (cmd.capture) begin
				seq_q <= cls_in;
				cnt_q <= '0;
				case (cls_in)
					CLS_PRINT: if (store_ok) wp_q <= wp_q + 5'd1;
					CLS_BS: if (wp_q != '0) wp_q <= wp_q - 5'd1;
					CLS_ESC: wp_q <= '0;
					default: wp_q <= wp_q;
				endcase
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 5'd1;
			end
			if (cmd.load_done) begin
				wp_q <= '0;
			end
			if (cmd.load_echo || cmd.load_char || cmd.load_done) begin
				oval_q <= 1'b1;
			end else if (out_ready) begin
				oval_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			byte_q <= rx_byte;
		end
		if (cmd.load_echo) begin
			okind_q <= KIND_ECHO;
			odata_q <= echo_byte(seq_q, cnt_q[2:0], byte_q);
			olast_q <= echo_last;
		end else if (cmd.load_char) begin
			okind_q <= KIND_CHAR;
			odata_q <= {1'b0, rdata};
			olast_q <= 1'b0;
		end else if (cmd.load_done) begin
			okind_q <= KIND_DONE;
			odata_q <= {3'b000, wp_q};
			olast_q <= 1'b1;
		end
	end

	assign sts.cls_in = cls_in;
	assign sts.echo_last = echo_last;
	assign sts.rd_end = (cnt_q == wp_q);
	assign sts.slot_free = !oval_q || out_ready;

	assign out_valid = oval_q;
	assign out_kind = okind_q;
	assign out_data = odata_q;
	assign out_last = olast_q;

endmodule
